[sv/pulse_interval_bit_receiver_macros.svh]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_INTERVAL_BIT_RECEIVER_MACROS_SVH
`define PULSE_INTERVAL_BIT_RECEIVER_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define PIBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent follows.
`define PIBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pibr_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver package
// Widths, register indexes, reset values and shared types of the receiver.
// ----------------------------------------------------------------------------
package pibr_pkg;

  // Default parameter values.
  localparam int unsigned FRAME_BITS_DEF  = 40;
  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned MAX_FRAME_BITS  = 64;

  // Fixed field widths.
  localparam int unsigned WIN_WIDTH  = 16;
  localparam int unsigned GAP_WIDTH  = 24;
  localparam int unsigned FRAME_W    = 40;
  localparam int unsigned EDGE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 3'd4;

  // Configuration reset values.
  localparam logic [WIN_WIDTH-1:0] ONE_MIN_RST     = 16'd100;
  localparam logic [WIN_WIDTH-1:0] ONE_MAX_RST     = 16'd140;
  localparam logic [WIN_WIDTH-1:0] ZERO_MIN_RST    = 16'd60;
  localparam logic [WIN_WIDTH-1:0] ZERO_MAX_RST    = 16'd100;
  localparam logic [GAP_WIDTH-1:0] GAP_TIMEOUT_RST = 24'd5000000;

  typedef struct packed {
    logic [WIN_WIDTH-1:0] one_min;
    logic [WIN_WIDTH-1:0] one_max;
    logic [WIN_WIDTH-1:0] zero_min;
    logic [WIN_WIDTH-1:0] zero_max;
    logic [GAP_WIDTH-1:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_data;
    logic [EDGE_W-1:0]  edge_count;
    logic               overrun;
  } res_t;

  typedef struct packed {
    logic armed;
    logic overrun;
  } sts_t;

endpackage

[sv/pibr_ifs.sv]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver channel interfaces
// Valid/ready channels for line samples, frame results and register writes.
// ----------------------------------------------------------------------------
interface pibr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface pibr_out_if import pibr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FRAME_W-1:0] frame_data;
  logic [EDGE_W-1:0]  edge_count;
  logic               overrun;

  modport source (output valid, output frame_data, output edge_count, output overrun,
                  input ready);
  modport sink (input valid, input frame_data, input edge_count, input overrun,
                output ready);
endinterface

interface pibr_cfg_if import pibr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/pibr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver configuration registers
// Holds the bit windows and the gap timeout, written by index.
// ----------------------------------------------------------------------------
module pibr_cfg_regs import pibr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        REG_ONE_MIN:     cfg_d.one_min     = data_i[WIN_WIDTH-1:0];
        REG_ONE_MAX:     cfg_d.one_max     = data_i[WIN_WIDTH-1:0];
        REG_ZERO_MIN:    cfg_d.zero_min    = data_i[WIN_WIDTH-1:0];
        REG_ZERO_MAX:    cfg_d.zero_max    = data_i[WIN_WIDTH-1:0];
        REG_GAP_TIMEOUT: cfg_d.gap_timeout = data_i[GAP_WIDTH-1:0];
        default: ;  // Writes past the register list are dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_min     <= ONE_MIN_RST;
      cfg_q.one_max     <= ONE_MAX_RST;
      cfg_q.zero_min    <= ZERO_MIN_RST;
      cfg_q.zero_max    <= ZERO_MAX_RST;
      cfg_q.gap_timeout <= GAP_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/pibr_core.sv]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver core
// Edge detection, interval counting, bit classification and frame timeout.
// ----------------------------------------------------------------------------
module pibr_core import pibr_pkg::*; #(
  parameter int unsigned FRAME_BITS  = FRAME_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic level_i,
  input  cfg_t cfg_i,
  output logic res_vld_o,
  output res_t res_o,
  output sts_t sts_o
);

  localparam int unsigned BIW  = $clog2(FRAME_BITS + 1);
  localparam int unsigned IDXW = $clog2(FRAME_BITS);
  localparam int unsigned CMPW = (COUNT_WIDTH > GAP_WIDTH) ? COUNT_WIDTH : GAP_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   prev_q, prev_d;
  logic                   armed_q, armed_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [BIW-1:0]         idx_q, idx_d;
  logic                   ovr_q, ovr_d;
  logic [FRAME_BITS-1:0]  frame_q, frame_d;

  logic                   falling;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   is_one;
  logic                   is_zero;
  logic                   timeout;
  logic                   idx_full;
  logic [MAX_FRAME_BITS-1:0] frame_wide;

  assign falling  = prev_q & ~level_i;
  assign tick_inc = (armed_q && (tick_q != CNT_MAX)) ? tick_q + 1'b1 : tick_q;
  assign is_one   = (tick_inc >= COUNT_WIDTH'(cfg_i.one_min)) &&
                    (tick_inc <  COUNT_WIDTH'(cfg_i.one_max));
  assign is_zero  = (tick_inc >= COUNT_WIDTH'(cfg_i.zero_min)) &&
                    (tick_inc <  COUNT_WIDTH'(cfg_i.zero_max));
  assign timeout  = CMPW'(tick_inc) >= CMPW'(cfg_i.gap_timeout);
  assign idx_full = idx_q >= BIW'(FRAME_BITS);

  always_comb begin
    prev_d    = prev_q;
    armed_d   = armed_q;
    tick_d    = tick_q;
    idx_d     = idx_q;
    ovr_d     = ovr_q;
    frame_d   = frame_q;
    res_vld_o = 1'b0;
    if (step_i) begin
      prev_d = level_i;
      if (falling) begin
        tick_d = '0;
        if (!armed_q) begin
          armed_d = 1'b1;
        end else if (idx_full) begin
          ovr_d = 1'b1;
        end else begin
          // The one window wins where the two windows overlap.
          if (is_one) begin
            frame_d[idx_q[IDXW-1:0]] = 1'b1;
          end else if (is_zero) begin
            frame_d[idx_q[IDXW-1:0]] = 1'b0;
          end
          idx_d = idx_q + 1'b1;
        end
      end else if (armed_q && timeout) begin
        res_vld_o = 1'b1;
        armed_d   = 1'b0;
        idx_d     = '0;
        ovr_d     = 1'b0;
        tick_d    = '0;
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      armed_q <= 1'b0;
      tick_q  <= '0;
      idx_q   <= '0;
      ovr_q   <= 1'b0;
      frame_q <= '0;
    end else begin
      prev_q  <= prev_d;
      armed_q <= armed_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      ovr_q   <= ovr_d;
      frame_q <= frame_d;
    end
  end

  // The frame bits are kept across frames; only the low result bits leave.
  assign frame_wide       = MAX_FRAME_BITS'(frame_q);
  assign res_o.frame_data = frame_wide[FRAME_W-1:0];
  assign res_o.edge_count = EDGE_W'(idx_q);
  assign res_o.overrun    = ovr_q;

  assign sts_o.armed   = armed_q;
  assign sts_o.overrun = ovr_q;

endmodule

[sv/pulse_interval_bit_receiver.sv]
// ----------------------------------------------------------------------------
// Pulse interval bit receiver
// Decodes a single-wire sensor data line into frames by falling edge spacing.
// ----------------------------------------------------------------------------
// The receiver takes one sample of the data line per request on in_i and
// accepts a new sample in every cycle, as long as the result channel is not
// stalled with a frame pending. A sample is held in an input register and is
// processed by the state update once the core may step (edge detect,
// saturating tick counter, window compares and frame register); a frame
// result is then registered in the output register and offered on out_o.
// The first falling edge arms the receiver, each later falling edge stores one
// bit (or sets overrun once all frame bits are filled), and a gap of
// gap_timeout ticks without an edge emits frame_data, edge_count and overrun.
// While a result waits on out_o, processing and intake pause until it is taken.
// Register writes on cfg_i are always taken and should be made while idle.
// ----------------------------------------------------------------------------
`include "pulse_interval_bit_receiver_macros.svh"

module pulse_interval_bit_receiver import pibr_pkg::*; #(
  parameter int unsigned FRAME_BITS  = FRAME_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pibr_in_if.sink    in_i,
  pibr_out_if.source out_o,
  pibr_cfg_if.sink   cfg_i
);

  // Input register: one line sample waiting for the core.
  logic in_vld_q;
  logic in_lvl_q;

  // Output register: one finished frame waiting to be taken.
  logic out_vld_q;
  res_t out_q;

  cfg_t cfg;
  logic go;
  logic res_vld;
  res_t res;
  sts_t sts;

  // The core steps when a sample is held and the output register can take
  // whatever result that sample may cause.
  assign go         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || go;
  assign cfg_i.ready = 1'b1;

  pibr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  pibr_core #(
    .FRAME_BITS  (FRAME_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (go),
    .level_i   (in_lvl_q),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_o     (res),
    .sts_o     (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (go && res_vld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_lvl_q <= in_i.line_level;
    end
    if (go && res_vld) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.frame_data = out_q.frame_data;
  assign out_o.edge_count = out_q.edge_count;
  assign out_o.overrun    = out_q.overrun;

  // A frame that ends leaves the receiver disarmed.
  `PIBR_ASSERT_NXT(a_end_disarms, go && res_vld, !sts.armed, "frame end did not disarm")
  // Overrun can only build up while a frame is in progress.
  `PIBR_ASSERT_IMP(a_idle_no_ovr, !sts.armed, !sts.overrun, "overrun set while idle")
  // A reported overrun means every frame bit was filled.
  `PIBR_ASSERT_IMP(a_ovr_full, out_vld_q && out_q.overrun,
                   out_q.edge_count == EDGE_W'(FRAME_BITS), "overrun on a partial frame")
  // A held sample is not dropped while the core waits.
  `PIBR_ASSERT_NXT(a_in_held, in_vld_q && !go, in_vld_q, "stalled sample lost")

endmodule
